[design/rwah_pkg.sv]
// ----------------------------------------------------------------------------
// RSSI weighted-average handoff package
// Shared constants, transaction types and register codes for the handoff unit.
// ----------------------------------------------------------------------------
package rwah_pkg;

  // History window depth and the widths that follow from it.
  localparam int HISTORY_DEPTH = 32;
  localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W         = 8 + $clog2(HISTORY_DEPTH);
  localparam int WEIGHT_DEN    = HISTORY_DEPTH * (HISTORY_DEPTH + 1) / 2;
  localparam int DEN_LOG       = $clog2(WEIGHT_DEN);
  localparam int WSUM_W        = 8 + DEN_LOG;

  // Ceiling division by WEIGHT_DEN: the biased weighted sum stays below
  // 256 * WEIGHT_DEN, so a reciprocal with RECIP_SHIFT fraction bits is exact.
  localparam int U_W         = $clog2(256 * WEIGHT_DEN);
  localparam int RECIP_SHIFT = U_W + DEN_LOG;
  localparam int RECIP_W     = RECIP_SHIFT - DEN_LOG + 2;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << RECIP_SHIFT) + 64'(WEIGHT_DEN) - 64'd1) / 64'(WEIGHT_DEN);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
  localparam logic [U_W:0] DIV_BIAS = (U_W+1)'(129 * WEIGHT_DEN - 1);

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RSSI_THRESHOLD = 1'b0,
    CFG_HOLD_OFF       = 1'b1
  } cfg_reg_t;

  localparam logic signed [7:0] THRESHOLD_RST = -8'sd80;
  localparam logic [15:0]       WAIT_RST      = 16'd100;

  // Action codes of an input transaction.
  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_CLEAR  = 2'd1,
    ACT_ACK    = 2'd2
  } action_t;

  typedef struct packed {
    logic [1:0]        action;
    logic signed [7:0] rssi;
    logic [31:0]       now_time;
  } rwah_in_t;

  typedef struct packed {
    logic              handoff_request;
    logic              average_valid;
    logic signed [7:0] weighted_average;
    logic              change_pending;
  } rwah_out_t;

  // Hand-over from the history stage to the decision stage.
  typedef struct packed {
    logic [1:0]               action;
    logic                     avg_en;
    logic signed [WSUM_W-1:0] wsum;
    logic [31:0]              now_time;
  } rwah_s1_t;

endpackage

[design/rwah_hist.sv]
// ----------------------------------------------------------------------------
// RSSI history stage
// Holds the sample window, fill count and running plain and weighted sums,
// and registers each transaction with its updated weighted sum.
// ----------------------------------------------------------------------------
module rwah_hist
  import rwah_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  rwah_in_t in_data,
  input  logic     adv,
  output logic     s1_valid,
  output rwah_s1_t s1_data
);

  logic signed [7:0]        win_r [HISTORY_DEPTH];
  logic [CNT_W-1:0]         fill_r, fill_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic signed [WSUM_W-1:0] wsum_r, wsum_nxt;
  logic                     s1_valid_r, s1_valid_nxt;
  rwah_s1_t                 s1_r, s1_nxt;

  logic                     in_fire;
  logic                     full;
  logic                     shift_en;
  logic signed [SUM_W-1:0]  oldest;
  logic signed [SUM_W-1:0]  x_s;
  logic signed [WSUM_W-1:0] x_w;
  logic signed [WSUM_W-1:0] sum_w;

  localparam logic signed [WSUM_W-1:0] DEPTH_W = WSUM_W'(HISTORY_DEPTH);

  assign in_fire  = in_valid && in_ready;
  assign in_ready = !s1_valid_r || adv;
  assign full     = (fill_r == CNT_W'(HISTORY_DEPTH));

  // Slots not yet filled count as zero when they drop out of the window.
  assign oldest = full ? SUM_W'(win_r[0]) : '0;
  assign x_s    = SUM_W'(in_data.rssi);
  assign x_w    = WSUM_W'(in_data.rssi);
  assign sum_w  = WSUM_W'(sum_r);

  // Sum and fill-count update for the accepted transaction.
  always_comb begin
    fill_nxt = fill_r;
    sum_nxt  = sum_r;
    wsum_nxt = wsum_r;
    shift_en = 1'b0;
    s1_nxt   = s1_r;
    if (in_fire) begin
      s1_nxt.action   = in_data.action;
      s1_nxt.now_time = in_data.now_time;
      s1_nxt.avg_en   = 1'b0;
      case (in_data.action)
        ACT_SAMPLE: begin
          shift_en = 1'b1;
          sum_nxt  = sum_r - oldest + x_s;
          // Every sample moves down one weight; the new one takes the top.
          wsum_nxt = wsum_r - sum_w + x_w * DEPTH_W;
          if (!full) begin
            fill_nxt = fill_r + CNT_W'(1);
          end
          s1_nxt.avg_en = full;
        end
        ACT_CLEAR: begin
          fill_nxt = '0;
          sum_nxt  = '0;
          wsum_nxt = '0;
        end
        default: begin
        end
      endcase
      s1_nxt.wsum = wsum_nxt;
    end
  end

  // Stage occupancy.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      sum_r      <= '0;
      wsum_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      fill_r     <= fill_nxt;
      sum_r      <= sum_nxt;
      wsum_r     <= wsum_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Window shift line and stage payload.
  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
    if (shift_en) begin
      for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[HISTORY_DEPTH-1] <= in_data.rssi;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_data  = s1_r;

endmodule

[design/rwah_decide.sv]
// ----------------------------------------------------------------------------
// RSSI handoff decision stage
// Divides the weighted sum into a rounded-up average, applies the threshold
// and hold-off rules, and keeps the pending flag and result register.
// ----------------------------------------------------------------------------
module rwah_decide
  import rwah_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s1_valid,
  input  rwah_s1_t          s1_data,
  input  logic signed [7:0] rssi_threshold,
  input  logic [15:0]       hold_off_time,
  output logic              adv,
  output logic              out_valid,
  input  logic              out_ready,
  output rwah_out_t         out_data
);

  logic                     pending_r, pending_nxt;
  logic [31:0]              last_time_r, last_time_nxt;
  logic                     out_valid_r, out_valid_nxt;
  rwah_out_t                out_r, out_nxt;

  logic                     load;
  logic signed [U_W:0]      biased;
  logic [U_W-1:0]           udiv;
  logic [U_W+RECIP_W-1:0]   prod;
  logic [7:0]               quot;
  logic signed [7:0]        avg;
  logic [31:0]              elapsed;
  logic                     request;

  assign adv  = !out_valid_r || out_ready;
  assign load = s1_valid && adv;

  // ceil(W / D) = floor((W + D - 1 + 128 * D) / D) - 128, with the offset
  // keeping the dividend non-negative for the reciprocal multiply.
  assign biased = (U_W+1)'(s1_data.wsum) + $signed(DIV_BIAS);
  assign udiv   = biased[U_W-1:0];
  assign prod   = (U_W+RECIP_W)'(udiv) * (U_W+RECIP_W)'(RECIP);
  assign quot   = prod[RECIP_SHIFT+7:RECIP_SHIFT];
  assign avg    = {~quot[7], quot[6:0]};

  // Hold-off check in modulo-2^32 time.
  assign elapsed = s1_data.now_time - last_time_r;
  assign request = s1_data.avg_en && (avg < rssi_threshold) && !pending_r &&
                   (elapsed > {16'd0, hold_off_time});

  always_comb begin
    pending_nxt   = pending_r;
    last_time_nxt = last_time_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (load) begin
      case (s1_data.action)
        ACT_SAMPLE: begin
          if (request) begin
            pending_nxt   = 1'b1;
            last_time_nxt = s1_data.now_time;
          end
        end
        ACT_ACK: begin
          pending_nxt = 1'b0;
        end
        default: begin
        end
      endcase
      out_valid_nxt            = 1'b1;
      out_nxt.handoff_request  = request;
      out_nxt.average_valid    = s1_data.avg_en;
      out_nxt.weighted_average = s1_data.avg_en ? avg : '0;
      out_nxt.change_pending   = pending_nxt;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= 1'b0;
      last_time_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pending_r   <= pending_nxt;
      last_time_r <= last_time_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[design/rssi_weighted_average_handoff_unit.sv]
// The result of a transaction passes through the history stage register and then
// the decision stage result register before it is on the result port.
// Throughput: one transaction per cycle through both stages while not stalled.
// in_ready drops only while both stage registers are full and out_ready is low.
// Reset (rst_n low at a clock edge) empties the history and the pipeline,
// clears the pending flag and last request time, and restores both registers.
// ----------------------------------------------------------------------------
// RSSI weighted-average handoff unit
// Forms a linearly weighted window average of RSSI samples and raises a handoff
// request when a full-window average is below threshold, no change is pending
// and the hold-off time has passed since the last request.
module rssi_weighted_average_handoff_unit
  import rwah_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rwah_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rwah_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic signed [7:0] thr_r, thr_nxt;
  logic [15:0]       wait_r, wait_nxt;
  logic              adv;
  logic              s1_valid;
  rwah_s1_t          s1_data;

  // Configuration registers.
  always_comb begin
    thr_nxt  = thr_r;
    wait_nxt = wait_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_RSSI_THRESHOLD: thr_nxt  = cfg_wdata[7:0];
        CFG_HOLD_OFF:       wait_nxt = cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THRESHOLD_RST;
      wait_r <= WAIT_RST;
    end else begin
      thr_r  <= thr_nxt;
      wait_r <= wait_nxt;
    end
  end

  rwah_hist u_hist (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_data  (s1_data)
  );

  rwah_decide u_decide (
    .clk            (clk),
    .rst_n          (rst_n),
    .s1_valid       (s1_valid),
    .s1_data        (s1_data),
    .rssi_threshold (thr_r),
    .hold_off_time  (wait_r),
    .adv            (adv),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data)
  );

endmodule

[design/rwah_checker.sv]
// ----------------------------------------------------------------------------
// RSSI handoff unit port checker
// Watches the result channel of the handoff unit for rule violations.
// ----------------------------------------------------------------------------
module rwah_checker
  import rwah_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input rwah_out_t out_data
);

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result transaction changed while stalled");

  // A new request always leaves the change pending.
  a_req_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.handoff_request |-> out_data.change_pending)
    else $error("handoff request without pending change");

  // Without an average there is no value and no request.
  a_no_avg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.average_valid |->
      out_data.weighted_average == 8'sd0 && !out_data.handoff_request)
    else $error("average or request without a formed average");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind rssi_weighted_average_handoff_unit rwah_checker u_rwah_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
